// File: design/four_voice_sine_oscillator_bank_core_assert.svh
// Assertion macros for the four-voice sine oscillator bank.
// Used by the core top level; expects i_clk and i_rst_n in scope.
`ifndef FOUR_VOICE_SINE_OSCILLATOR_BANK_CORE_ASSERT_SVH
`define FOUR_VOICE_SINE_OSCILLATOR_BANK_CORE_ASSERT_SVH

// same-cycle implication
`define FVSOB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fvsob assertion failed");

// next-cycle implication
`define FVSOB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fvsob assertion failed");

`endif

// File: design/fvsob_pkg.sv
// Shared types and constants of the four-voice sine oscillator bank.
// No dependencies.
package fvsob_pkg;

    localparam int STEP_W     = 24;
    localparam int AMP_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int NUM_VOICES = 4;

    // register indexes
    localparam logic [2:0] REG_STEP_ONE  = 3'd0;
    localparam logic [2:0] REG_STEP_TWO  = 3'd1;
    localparam logic [2:0] REG_STEP_THREE = 3'd2;
    localparam logic [2:0] REG_STEP_FOUR = 3'd3;
    localparam logic [2:0] REG_AMP_ONE   = 3'd4;
    localparam logic [2:0] REG_AMP_TWO   = 3'd5;
    localparam logic [2:0] REG_AMP_THREE = 3'd6;
    localparam logic [2:0] REG_AMP_FOUR  = 3'd7;

    localparam logic [STEP_W-1:0] RST_STEP_ONE   = 24'd129346;
    localparam logic [STEP_W-1:0] RST_STEP_TWO   = 24'd152172;
    localparam logic [STEP_W-1:0] RST_STEP_THREE = 24'd87499;
    localparam logic [STEP_W-1:0] RST_STEP_FOUR  = 24'd144564;
    localparam logic [AMP_W-1:0]  RST_AMP_ONE    = 16'd32768;
    localparam logic [AMP_W-1:0]  RST_AMP_TWO    = 16'd26214;
    localparam logic [AMP_W-1:0]  RST_AMP_THREE  = 16'd16384;
    localparam logic [AMP_W-1:0]  RST_AMP_FOUR   = 16'd19661;

    // 0.3 as unsigned Q0.16
    localparam logic [14:0] MIX_GAIN = 15'd19661;
    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [NUM_VOICES-1:0][STEP_W-1:0] step;
        logic [NUM_VOICES-1:0][AMP_W-1:0]  amp;
    } t_cfg;

endpackage

// File: design/fvsob_regs.sv
// APB-style configuration registers: four phase steps and four amplitudes.
// Depends on fvsob_pkg.
module fvsob_regs #(
    parameter int PHASE_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fvsob_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [fvsob_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [fvsob_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready,
    output fvsob_pkg::t_cfg                    o_cfg
);
    import fvsob_pkg::*;

    localparam logic [STEP_W-1:0] STEP_MASK = STEP_W'((64'd1 << PHASE_BITS) - 64'd1);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step[0] <= RST_STEP_ONE & STEP_MASK;
            r_cfg.step[1] <= RST_STEP_TWO & STEP_MASK;
            r_cfg.step[2] <= RST_STEP_THREE & STEP_MASK;
            r_cfg.step[3] <= RST_STEP_FOUR & STEP_MASK;
            r_cfg.amp[0]  <= RST_AMP_ONE;
            r_cfg.amp[1]  <= RST_AMP_TWO;
            r_cfg.amp[2]  <= RST_AMP_THREE;
            r_cfg.amp[3]  <= RST_AMP_FOUR;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STEP_ONE:   r_cfg.step[0] <= pwdata[STEP_W-1:0] & STEP_MASK;
                REG_STEP_TWO:   r_cfg.step[1] <= pwdata[STEP_W-1:0] & STEP_MASK;
                REG_STEP_THREE: r_cfg.step[2] <= pwdata[STEP_W-1:0] & STEP_MASK;
                REG_STEP_FOUR:  r_cfg.step[3] <= pwdata[STEP_W-1:0] & STEP_MASK;
                REG_AMP_ONE:    r_cfg.amp[0]  <= pwdata[AMP_W-1:0];
                REG_AMP_TWO:    r_cfg.amp[1]  <= pwdata[AMP_W-1:0];
                REG_AMP_THREE:  r_cfg.amp[2]  <= pwdata[AMP_W-1:0];
                REG_AMP_FOUR:   r_cfg.amp[3]  <= pwdata[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STEP_ONE:   prdata = CFG_DATA_W'(r_cfg.step[0]);
            REG_STEP_TWO:   prdata = CFG_DATA_W'(r_cfg.step[1]);
            REG_STEP_THREE: prdata = CFG_DATA_W'(r_cfg.step[2]);
            REG_STEP_FOUR:  prdata = CFG_DATA_W'(r_cfg.step[3]);
            REG_AMP_ONE:    prdata = CFG_DATA_W'(r_cfg.amp[0]);
            REG_AMP_TWO:    prdata = CFG_DATA_W'(r_cfg.amp[1]);
            REG_AMP_THREE:  prdata = CFG_DATA_W'(r_cfg.amp[2]);
            REG_AMP_FOUR:   prdata = CFG_DATA_W'(r_cfg.amp[3]);
            default:        prdata = '0;
        endcase
    end

endmodule

// File: design/fvsob_sine.sv
// Sine lookup: quarter-wave ROM with quadrant folding, registered read.
// Depends on fvsob_pkg (pi/2 constant). The sine follows the phase in the next cycle.
module fvsob_sine #(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                    i_clk,
    input  logic [PHASE_BITS-1:0]   i_phase,
    output logic [14:0]             o_mag,
    output logic                    o_neg,
    output logic signed [15:0]      o_sine
);
    import fvsob_pkg::*;

    localparam int TB    = SINE_TABLE_BITS;
    localparam int QSIZE = 1 << (TB - 2);

    // Taylor series to ninth order in Q2.30, rounded to Q1.15, clamped
    function automatic logic [14:0] f_qsine(input longint unsigned kk);
        longint unsigned x, x2, t3, t5, t7, t9, s, q;
        x  = (kk * HALF_PI_Q30) >> (TB - 2);
        x2 = (x * x) >> 30;
        t3 = ((x * x2) >> 30) / 64'd6;
        t5 = ((t3 * x2) >> 30) / 64'd20;
        t7 = ((t5 * x2) >> 30) / 64'd42;
        t9 = ((t7 * x2) >> 30) / 64'd72;
        s  = (x + t5 + t9) - (t3 + t7);
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767) q = 64'd32767;
        return q[14:0];
    endfunction

    logic [14:0]   w_rom [QSIZE+1];
    logic [TB-1:0] w_idx;
    logic [1:0]    w_quad;
    logic [TB-2:0] w_k;
    logic [TB-2:0] w_kk;
    logic [14:0]   r_mag;
    logic          r_neg;

    for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
        localparam logic [14:0] ROM_VAL = f_qsine(longint'(g));
        assign w_rom[g] = ROM_VAL;
    end

    assign w_idx  = i_phase[PHASE_BITS-1 -: TB];
    assign w_quad = w_idx[TB-1:TB-2];
    assign w_k    = {1'b0, w_idx[TB-3:0]};
    // odd quadrants run the quarter wave backwards
    assign w_kk   = w_quad[0] ? ((TB-1)'(QSIZE) - w_k) : w_k;

    always_ff @(posedge i_clk) begin
        r_mag <= w_rom[w_kk];
        r_neg <= w_quad[1];
    end

    assign o_mag  = r_mag;
    assign o_neg  = r_neg;
    assign o_sine = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule

// File: design/four_voice_sine_oscillator_bank_core.sv
// Four-voice sine oscillator bank with LFO vibrato on voices two and four.
// Input channel: one item is one sample tick; tdata[0] marks the last frame of a buffer.
// Output channel: one signed sample per item in tdata, the frame mark in tlast.
// Configuration: APB-style port, eight registers at byte address 4*i
// (four 24-bit phase steps, four Q1.15 amplitudes); write only while idle.
// Timing: an item is accepted only once the previous one has left the sequencer;
// its result is valid when ready rises again. The sequencer runs one shared
// multiplier and one sine ROM port: LFO steps (lookup, times depth, modulate), per
// voice (advance, lookup, times gain, times amplitude, accumulate), then a rounding step.
// The output register holds a result while the receiver stalls; the next item
// is accepted meanwhile, and its result waits in the last step until the
// register empties. Reset clears all phases, restores the register defaults
// and empties the output register.
// Depends on fvsob_pkg, fvsob_regs, fvsob_sine and the assertion macro header.
`include "four_voice_sine_oscillator_bank_core_assert.svh"

module four_voice_sine_oscillator_bank_core #(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  logic [7:0]                               i_s_axis_tdata,   // [0] last_frame
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]         o_m_axis_tdata,   // sample
    output logic                                     o_m_axis_tlast,   // last
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [fvsob_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [fvsob_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [fvsob_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                     pready
);
    import fvsob_pkg::*;

    localparam int PB   = PHASE_BITS;
    localparam int SB   = SAMPLE_BITS;
    localparam int OD_W = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam longint unsigned LFO_STEP_L =
        ((64'd1 << PB) * 64'd6366198 + 64'd500000000000) / 64'd1000000000000;
    localparam longint unsigned LFO_DEPTH_L =
        ((64'd1 << PB) * 64'd954930 + 64'd500000000) / 64'd1000000000;
    localparam int DEPTH_W = $clog2(LFO_DEPTH_L + 1);

    localparam int MA_W  = 32;
    localparam int MB_W  = (DEPTH_W > AMP_W) ? DEPTH_W : AMP_W;
    localparam int PW    = MA_W + MB_W + 1;
    localparam int SUM_W = 50;
    localparam int SH    = 46 - (SB - 1);

    localparam logic [PB-1:0]          LFO_STEP  = PB'(LFO_STEP_L);
    localparam logic [MB_W-1:0]        LFO_DEPTH = MB_W'(LFO_DEPTH_L);
    localparam logic signed [PW-1:0]   LFO_HALF  = PW'(64'd16384);
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << (SH - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SAT_LO   = -SAT_HI - SUM_W'(64'd1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LFO_RD, ST_LFO_MUL, ST_LFO_MOD,
        ST_V_ADV, ST_V_RD, ST_V_MG, ST_V_MA, ST_V_ACC, ST_FIN
    } t_state;

    t_cfg                       w_cfg;
    t_state                     r_state;
    logic [PB-1:0]              r_lfo_phase;
    logic [PB-1:0]              r_phase [NUM_VOICES];
    logic [1:0]                 r_vidx;
    logic                       r_lfo_neg;
    logic [PB-1:0]              r_mod;
    logic signed [PW-1:0]       r_prod;
    logic signed [SUM_W-1:0]    r_acc;
    logic                       r_last;
    logic                       r_ovalid;
    logic [SB-1:0]              r_sample;
    logic                       r_olast;

    logic                       w_in_acc;
    logic [PB-1:0]              w_sine_phase;
    logic [14:0]                w_mag;
    logic                       w_neg;
    logic signed [15:0]         w_sine;
    logic signed [MA_W-1:0]     w_mul_a;
    logic [MB_W-1:0]            w_mul_b;
    logic signed [PW-1:0]       w_prod;
    logic signed [PW-1:0]       w_lfo_sum;
    logic [PB-1:0]              w_lfo_mag;
    logic [PB-1:0]              w_step;
    logic [PB-1:0]              w_new_phase;
    logic signed [SUM_W-1:0]    w_rnd_sum;
    logic signed [SUM_W-1:0]    w_rnd;
    logic [SB-1:0]              w_sat;
    logic                       w_out_free;

    fvsob_regs #(.PHASE_BITS(PHASE_BITS)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_sine_phase = (r_state == ST_LFO_RD) ? r_lfo_phase : r_phase[r_vidx];

    fvsob_sine #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_phase (w_sine_phase),
        .o_mag   (w_mag),
        .o_neg   (w_neg),
        .o_sine  (w_sine)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_LFO_MUL: begin
                w_mul_a = MA_W'($signed({1'b0, w_mag}));
                w_mul_b = LFO_DEPTH;
            end
            ST_V_MG: begin
                w_mul_a = MA_W'(w_sine);
                w_mul_b = MB_W'(MIX_GAIN);
            end
            default: begin
                w_mul_a = $signed(r_prod[MA_W-1:0]);
                w_mul_b = MB_W'(w_cfg.amp[r_vidx]);
            end
        endcase
    end
    assign w_prod = w_mul_a * $signed({1'b0, w_mul_b});

    // LFO modulation: sign(s) * round(|s| * depth / 2^15)
    assign w_lfo_sum = r_prod + LFO_HALF;
    assign w_lfo_mag = w_lfo_sum[PB+14:15];

    // voices two and four (odd index) get the vibrato
    assign w_step      = PB'(w_cfg.step[r_vidx]) + (r_vidx[0] ? r_mod : '0);
    assign w_new_phase = r_phase[r_vidx] + w_step;

    // round half up, then saturate
    assign w_rnd_sum = r_acc + RND_HALF;
    assign w_rnd     = w_rnd_sum >>> SH;
    always_comb begin
        if (w_rnd > SAT_HI)      w_sat = SAT_HI[SB-1:0];
        else if (w_rnd < SAT_LO) w_sat = SAT_LO[SB-1:0];
        else                     w_sat = w_rnd[SB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lfo_phase <= '0;
            for (int v = 0; v < NUM_VOICES; v++) r_phase[v] <= '0;
            r_vidx      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            // load a finished result, else drop the one the receiver takes
            if ((r_state == ST_FIN) && w_out_free) r_ovalid <= 1'b1;
            else if (i_m_axis_tready)            r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_lfo_phase <= r_lfo_phase + LFO_STEP;
                        r_last      <= i_s_axis_tdata[0];
                        r_acc       <= '0;
                        r_vidx      <= '0;
                        r_state     <= ST_LFO_RD;
                    end
                end
                ST_LFO_RD: r_state <= ST_LFO_MUL;
                ST_LFO_MUL: begin
                    r_prod    <= w_prod;
                    r_lfo_neg <= w_neg;
                    r_state   <= ST_LFO_MOD;
                end
                ST_LFO_MOD: begin
                    r_mod   <= r_lfo_neg ? (PB'(0) - w_lfo_mag) : w_lfo_mag;
                    r_state <= ST_V_ADV;
                end
                ST_V_ADV: begin
                    r_phase[r_vidx] <= w_new_phase;
                    r_state         <= ST_V_RD;
                end
                ST_V_RD: r_state <= ST_V_MG;
                ST_V_MG: begin
                    r_prod  <= w_prod;
                    r_state <= ST_V_MA;
                end
                ST_V_MA: begin
                    r_prod  <= w_prod;
                    r_state <= ST_V_ACC;
                end
                ST_V_ACC: begin
                    r_acc <= r_acc + SUM_W'(r_prod);
                    if (r_vidx == 2'(NUM_VOICES - 1)) begin
                        r_vidx  <= '0;
                        r_state <= ST_FIN;
                    end else begin
                        r_vidx  <= r_vidx + 2'd1;
                        r_state <= ST_V_ADV;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_sample <= w_sat;
                        r_olast  <= r_last;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OD_W'(r_sample);
    assign o_m_axis_tlast  = r_olast;

    `FVSOB_ASSERT_NEXT(a_busy_after_accept, w_in_acc, !o_s_axis_tready)
    `FVSOB_ASSERT_NOW(a_result_from_fin, $rose(r_ovalid), $past(r_state) == ST_FIN)
    `FVSOB_ASSERT_NOW(a_idle_voice_zero, o_s_axis_tready, r_vidx == 2'd0)
    `FVSOB_ASSERT_NEXT(a_fin_waits_full, (r_state == ST_FIN) && r_ovalid && !i_m_axis_tready,
                       (r_state == ST_FIN) && r_ovalid)

endmodule
